FILE: rtl/core/banded_local_align_score_macros.svh
// Assertion macros shared by the banded local alignment score checkers.
`ifndef BANDED_LOCAL_ALIGN_SCORE_MACROS_SVH
`define BANDED_LOCAL_ALIGN_SCORE_MACROS_SVH

// Same-cycle implication, reported through $error.
`define BLAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reported through $error.
`define BLAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/blas_pkg.sv
// Shared types and constants of the banded local alignment score block.
`timescale 1ns / 1ps
`default_nettype none
package blas_pkg;

  localparam int unsigned SCORE_W   = 24;
  localparam int unsigned DIR_W     = 3;
  localparam int unsigned SUM_W     = 27;
  localparam int unsigned SCORE_SAT = 16777215;

  // beat kinds on the input stream
  localparam logic [1:0] KIND_REF    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // traceback direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 3'd0;
  localparam logic [DIR_W-1:0] DIR_EQ   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_X    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_I    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_D    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MATCH    = 3'd0;
  localparam logic [2:0] CFG_MISMATCH = 3'd1;
  localparam logic [2:0] CFG_OPEN_RD  = 3'd2;
  localparam logic [2:0] CFG_OPEN_RF  = 3'd3;
  localparam logic [2:0] CFG_EXT_BASE = 3'd4;
  localparam logic [2:0] CFG_EXT_DEC  = 3'd5;
  localparam logic [2:0] CFG_EXT_CAP  = 3'd6;
  localparam logic [2:0] CFG_BAND_W   = 3'd7;

  typedef struct packed {
    logic ref_load;
    logic row_start;
    logic cur_load;
    logic mul;
    logic cand;
    logic dec;
    logic slide;
    logic finish;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic col_last;
    logic bw_small;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/blas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module blas_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]                  rdata_o
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/core/blas_ctrl.sv
// Sequencer of the banded alignment block: beat intake, column steps, clearing.
`timescale 1ns / 1ps
`default_nettype none
module blas_ctrl
  import blas_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_kind_i,
  input  wire status_t    sts_i,
  output logic            in_ready_o,
  output cmd_t            cmd_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_PCAP  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_CAND  = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_SLIDE = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && ((in_kind_i != KIND_FINISH) || !sts_i.out_busy);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_REF: cmd_o.ref_load = 1'b1;
            KIND_READ: begin
              cmd_o.row_start = 1'b1;
              state_d = sts_i.bw_small ? S_SLIDE : S_PCAP;
            end
            KIND_FINISH: begin
              cmd_o.finish = 1'b1;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_PCAP: begin
        cmd_o.cur_load = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_CAND;
      end
      S_CAND: begin
        cmd_o.cand = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d = sts_i.col_last ? S_SLIDE : S_RD;
      end
      S_SLIDE: begin
        cmd_o.slide = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/blas_datapath.sv
// Datapath: config registers, band row and window memories, cell scoring, result.
`timescale 1ns / 1ps
`default_nettype none
module blas_datapath
  import blas_pkg::*;
#(
  parameter int unsigned BAND    = 64,
  parameter int unsigned RUN_MAX = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic [7:0]  in_base_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [14:0] cfg_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [63:0]      out_data_o,
  output status_t          sts_o
);
  localparam int unsigned AW  = $clog2(BAND);
  localparam int unsigned RW  = $clog2(RUN_MAX + 1);
  localparam int unsigned CW  = SCORE_W + DIR_W + RW;
  localparam int unsigned PW  = RW + 14;
  localparam int unsigned BWW = (AW + 1 > 7) ? AW + 1 : 7;

  // configuration
  logic        [13:0] match_q, decay_q;
  logic signed [14:0] mism_q, oread_q, oref_q, ebase_q, ecap_q;
  logic        [6:0]  bw_q;

  // control state
  logic [AW-1:0] head_q, col_q, clr_q;
  logic [AW:0]   fill_q;
  logic [15:0]   rows_q, top_row_q;
  logic signed [24:0] top_score_q;
  logic [AW-1:0] top_col_q;
  logic          out_valid_q;

  // payload
  logic [7:0]         base_q, ref_q;
  logic [SCORE_W-1:0] cur_q, l_score_q, u_score_q;
  logic [DIR_W-1:0]   l_dir_q, u_dir_q;
  logic [RW-1:0]      l_run_q, u_run_q;
  logic [PW-1:0]      uprod_q, lprod_q;
  logic signed [SUM_W-1:0] up_c_q, left_c_q, diag_c_q;
  logic [RW-1:0]      ins_q, del_q;
  logic               eq_q;
  logic [63:0]        out_q;

  // band width in use
  logic [BWW-1:0] bw_ext, bw_lim;
  logic [AW:0]    bw_eff, col_nx;
  assign bw_ext = BWW'(bw_q);
  assign bw_lim = (bw_ext > BWW'(BAND)) ? BWW'(BAND) : bw_ext;
  assign bw_eff = (AW+1)'(bw_lim);
  assign col_nx = {1'b0, col_q} + (AW+1)'(1);

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= (AW+1)'(BAND)) s = s - (AW+1)'(BAND);
      return s[AW-1:0];
    end
  endfunction

  function automatic logic signed [14:0] pen(input logic [PW-1:0] prod);
    logic signed [PW+1:0] p;
    begin
      p = $signed({2'b00, prod}) + (PW+2)'(ebase_q);
      return (p < (PW+2)'(ecap_q)) ? 15'(p) : ecap_q;
    end
  endfunction

  // memories
  logic          cell_we, ref_we;
  logic [AW-1:0] cell_wa, cell_ra, ref_wa, ref_ra;
  logic [CW-1:0] cell_wd, cell_rd;
  logic [7:0]    ref_wd, ref_rd;
  logic [SCORE_W-1:0] new_score;
  logic [DIR_W-1:0]   new_dir;
  logic [RW-1:0]      new_run;

  assign cell_we = cmd_i.clr || cmd_i.dec;
  assign cell_wa = cmd_i.clr ? clr_q : col_q;
  assign cell_wd = cmd_i.clr ? '0 : {new_score, new_dir, new_run};
  assign cell_ra = cmd_i.row_start ? AW'(1) : col_nx[AW-1:0];

  assign ref_we = cmd_i.clr || cmd_i.slide || (cmd_i.ref_load && (fill_q < (AW+1)'(BAND)));
  assign ref_wa = cmd_i.clr ? clr_q : (cmd_i.slide ? head_q : wrap(head_q, fill_q[AW-1:0]));
  assign ref_wd = cmd_i.ref_load ? in_base_i : 8'd0;
  assign ref_ra = wrap(head_q, col_q - AW'(1));

  blas_ram #(.W(CW), .DEPTH(BAND)) u_cell_ram (
    .clk_i, .we_i(cell_we), .waddr_i(cell_wa), .wdata_i(cell_wd),
    .raddr_i(cell_ra), .rdata_o(cell_rd)
  );

  blas_ram #(.W(8), .DEPTH(BAND)) u_ref_ram (
    .clk_i, .we_i(ref_we), .waddr_i(ref_wa), .wdata_i(ref_wd),
    .raddr_i(ref_ra), .rdata_o(ref_rd)
  );

  // up neighbor, gated past the band edge
  logic               up_ok;
  logic [SCORE_W-1:0] rd_score;
  logic [DIR_W-1:0]   rd_dir;
  logic [RW-1:0]      rd_run;
  assign up_ok    = col_nx < bw_eff;
  assign rd_score = up_ok ? cell_rd[CW-1 -: SCORE_W] : '0;
  assign rd_dir   = up_ok ? cell_rd[RW +: DIR_W] : DIR_STOP;
  assign rd_run   = up_ok ? cell_rd[RW-1:0] : '0;

  // candidate scores
  logic signed [SUM_W-1:0] us, ls, ds, up_c, left_c, diag_c;
  logic [RW-1:0] ins_r, del_r;
  logic          eq;
  always_comb begin
    us = SUM_W'($signed({1'b0, u_score_q}));
    ls = SUM_W'($signed({1'b0, l_score_q}));
    ds = SUM_W'($signed({1'b0, cur_q}));
    eq = base_q == ref_q;
    diag_c = ds + (eq ? SUM_W'($signed({1'b0, match_q})) : SUM_W'(mism_q));
    if (u_dir_q == DIR_I) begin
      ins_r = u_run_q;
      up_c  = (u_score_q == '0) ? '0 : us + SUM_W'(pen(uprod_q));
    end else begin
      ins_r = '0;
      up_c  = us + SUM_W'(oread_q);
    end
    if (l_dir_q == DIR_D) begin
      del_r  = l_run_q;
      left_c = (l_score_q == '0) ? '0 : ls + SUM_W'(pen(lprod_q));
    end else begin
      del_r  = '0;
      left_c = ls + SUM_W'(oref_q);
    end
  end

  // best move, tie order as specified
  logic signed [SUM_W-1:0] mx;
  logic [RW-1:0] del_inc, ins_inc;
  always_comb begin
    del_inc = (del_q >= RW'(RUN_MAX)) ? RW'(RUN_MAX) : del_q + RW'(1);
    ins_inc = (ins_q >= RW'(RUN_MAX)) ? RW'(RUN_MAX) : ins_q + RW'(1);
    mx = '0;
    if (left_c_q > mx) mx = left_c_q;
    if (diag_c_q > mx) mx = diag_c_q;
    if (up_c_q > mx) mx = up_c_q;
    if (del_q != '0 && mx == left_c_q) begin
      new_dir = DIR_D; new_run = del_inc;
    end else if (ins_q != '0 && mx == up_c_q) begin
      new_dir = DIR_I; new_run = ins_inc;
    end else if (mx == diag_c_q) begin
      new_dir = eq_q ? DIR_EQ : DIR_X; new_run = '0;
    end else if (mx == left_c_q) begin
      new_dir = DIR_D; new_run = RW'(1);
    end else if (mx == up_c_q) begin
      new_dir = DIR_I; new_run = RW'(1);
    end else begin
      new_dir = DIR_STOP; new_run = '0;
    end
    new_score = (mx > SUM_W'(SCORE_SAT)) ? SCORE_W'(SCORE_SAT) : mx[SCORE_W-1:0];
  end

  // result fields
  logic [15:0] res_row, res_clip;
  logic [5:0]  res_col;
  always_comb begin
    if (rows_q == 16'd0) begin
      res_row = 16'd2; res_col = 6'd2; res_clip = 16'd0;
    end else begin
      res_row  = top_row_q;
      res_col  = 6'(top_col_q);
      res_clip = (rows_q > top_row_q) ? rows_q - top_row_q - 16'd1 : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 14'd200;  mism_q  <= -15'sd500; oread_q <= -15'sd500;
      oref_q  <= -15'sd500; ebase_q <= -15'sd500; decay_q <= 14'd15;
      ecap_q  <= -15'sd100; bw_q    <= 7'd64;
      head_q <= '0; col_q <= '0; clr_q <= '0; fill_q <= '0;
      rows_q <= '0; top_row_q <= '0; top_score_q <= -25'sd100; top_col_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MATCH:    match_q <= cfg_data_i[13:0];
          CFG_MISMATCH: mism_q  <= cfg_data_i;
          CFG_OPEN_RD:  oread_q <= cfg_data_i;
          CFG_OPEN_RF:  oref_q  <= cfg_data_i;
          CFG_EXT_BASE: ebase_q <= cfg_data_i;
          CFG_EXT_DEC:  decay_q <= cfg_data_i[13:0];
          CFG_EXT_CAP:  ecap_q  <= cfg_data_i;
          CFG_BAND_W:   bw_q    <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= (clr_q == AW'(BAND - 1)) ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.ref_load && (fill_q < (AW+1)'(BAND))) fill_q <= fill_q + (AW+1)'(1);
      if (cmd_i.row_start) col_q <= AW'(1);
      if (cmd_i.dec) begin
        col_q <= col_nx[AW-1:0];
        if (SUM_W'($signed({1'b0, new_score})) > SUM_W'(top_score_q)) begin
          top_score_q <= 25'($signed({1'b0, new_score}));
          top_row_q   <= rows_q;
          top_col_q   <= col_q - AW'(1);
        end
      end
      if (cmd_i.slide) begin
        head_q <= wrap(head_q, AW'(1));
        if (fill_q != '0) fill_q <= fill_q - (AW+1)'(1);
        if (rows_q != 16'hFFFF) rows_q <= rows_q + 16'd1;
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        head_q <= '0; fill_q <= '0; rows_q <= '0; top_row_q <= '0;
        top_score_q <= -25'sd100; top_col_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_start) begin
      base_q <= in_base_i;
      l_score_q <= '0; l_dir_q <= DIR_STOP; l_run_q <= '0;
    end
    if (cmd_i.cur_load) cur_q <= cell_rd[CW-1 -: SCORE_W];
    if (cmd_i.mul) begin
      u_score_q <= rd_score; u_dir_q <= rd_dir; u_run_q <= rd_run;
      ref_q   <= ref_rd;
      uprod_q <= PW'(rd_run) * PW'(decay_q);
      lprod_q <= PW'(l_run_q) * PW'(decay_q);
    end
    if (cmd_i.cand) begin
      up_c_q <= up_c; left_c_q <= left_c; diag_c_q <= diag_c;
      ins_q <= ins_r; del_q <= del_r; eq_q <= eq;
    end
    if (cmd_i.dec) begin
      l_score_q <= new_score; l_dir_q <= new_dir; l_run_q <= new_run;
      cur_q <= u_score_q;
    end
    if (cmd_i.finish) begin
      out_q <= {1'b0, res_clip, res_col, res_row, top_score_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign sts_o.clr_last = clr_q == AW'(BAND - 1);
  assign sts_o.col_last = col_nx == bw_eff;
  assign sts_o.bw_small = bw_eff < (AW+1)'(2);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
endmodule
`default_nettype wire

FILE: rtl/core/banded_local_align_score.sv
// Top level of the banded local alignment score block.
`timescale 1ns / 1ps
`default_nettype none
// Banded Smith-Waterman scorer with a decaying gap-extension penalty. Beats
// come in on the slave stream: tuser holds the kind (reference base, read base,
// finish) and tdata the base. A reference beat is taken while the block stays
// idle. A read beat scores band columns 1..bw-1 (bw = band_width, at most
// BAND) one column at a time through read, multiply, candidate and decide
// steps on the band row memory, after setup and before a window slide; when
// bw is below 2 only the window slide runs. A finish beat loads the result
// register (best score, row, column, end clip) and then sweeps both memories
// clear, one entry per cycle, during which no beat is taken; the same sweep
// runs after reset. Configuration writes land at any time but belong to idle
// periods. Like every beat a finish beat waits for idle, and it also waits
// while an earlier result has not been taken.
module banded_local_align_score
  import blas_pkg::*;
#(
  parameter int unsigned BAND    = 64,
  parameter int unsigned RUN_MAX = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] base
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [24:0] best_score, [40:25] best_read_row, [46:41] best_band_col,
  // [62:47] end_clip, [63] zero
  output logic [63:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [14:0] cfg_data_i
);
  cmd_t    cmd;
  status_t sts;

  blas_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_kind_i(s_axis_tuser), .sts_i(sts),
    .in_ready_o(s_axis_tready), .cmd_o(cmd)
  );

  blas_datapath #(.BAND(BAND), .RUN_MAX(RUN_MAX)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_base_i(s_axis_tdata),
    .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata), .sts_o(sts)
  );
endmodule
`default_nettype wire

FILE: rtl/core/blas_checker.sv
// Port-level checker for the banded local alignment score block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "banded_local_align_score_macros.svh"
module blas_checker
  import blas_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready
);
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  `BLAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped")
  `BLAS_ASSERT_NEXT(a_finish_out, acc && s_axis_tuser == KIND_FINISH, m_axis_tvalid, "finish gave no result")
  `BLAS_ASSERT_NEXT(a_finish_busy, acc && s_axis_tuser == KIND_FINISH, !s_axis_tready, "no clearing after finish")
  `BLAS_ASSERT_NEXT(a_row_busy, acc && s_axis_tuser == KIND_READ, !s_axis_tready, "read row took one cycle")
  `BLAS_ASSERT_SAME(a_fin_wait, s_axis_tready && s_axis_tuser == KIND_FINISH && m_axis_tvalid, m_axis_tready, "finish taken over pending result")
endmodule

bind banded_local_align_score blas_checker u_blas_checker (.*);
`default_nettype wire

FILE: tb/banded_local_align_score_tb.sv
// Self-checking testbench for the banded local alignment score block.
`timescale 1ns / 1ps
`default_nettype none
module banded_local_align_score_tb;
  import blas_pkg::*;

  localparam int unsigned BAND      = 64;
  localparam int unsigned RUN_MAX   = 255;
  localparam logic [1:0]  KIND_NONE = 2'd3;     // unused kind, dropped by the block
  localparam int          SETTLE    = 400;      // outlasts the longest read beat
  localparam longint      CYC_LIMIT = 4000000;
  localparam int          HOLD_CYC  = 3000;

  typedef struct {
    logic signed [24:0] score;
    logic [15:0]        row;
    logic [5:0]         col;
    logic [15:0]        clip;
  } align_res_t;

  // Aligner model plus the queue of finish results still owed by the block.
  class align_board;
    int                 errors;
    int                 seen;
    int                 beats;
    align_res_t         owed[$];
    int                 match_s, mism_s, open_rd, open_rf, ext_base, ext_dec, ext_cap, bw_reg;
    longint             band_sc[BAND];
    logic [DIR_W-1:0]   dir[BAND];
    int                 run[BAND];
    logic [7:0]         win[BAND];
    int                 fill, rows, top_row, top_col;
    longint             top_sc;

    function new();
      errors = 0; seen = 0; beats = 0;
      match_s = 200; mism_s = -500; open_rd = -500; open_rf = -500;
      ext_base = -500; ext_dec = 15; ext_cap = -100; bw_reg = 64;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < BAND; i++) begin
        band_sc[i] = 0; dir[i] = DIR_STOP; run[i] = 0; win[i] = 8'd0;
      end
      fill = 0; rows = 0; top_sc = -100; top_row = 0; top_col = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] v);
      case (idx)
        CFG_MATCH:    match_s  = int'(v[13:0]);
        CFG_MISMATCH: mism_s   = int'($signed(v));
        CFG_OPEN_RD:  open_rd  = int'($signed(v));
        CFG_OPEN_RF:  open_rf  = int'($signed(v));
        CFG_EXT_BASE: ext_base = int'($signed(v));
        CFG_EXT_DEC:  ext_dec  = int'(v[13:0]);
        CFG_EXT_CAP:  ext_cap  = int'($signed(v));
        CFG_BAND_W:   bw_reg   = int'(v[6:0]);
        default: ;
      endcase
    endfunction

    function longint gap_ext(int r);
      longint p;
      p = longint'(ext_base) + longint'(r) * longint'(ext_dec);
      return (p < ext_cap) ? p : longint'(ext_cap);
    endfunction

    function int bump(int r);
      return (r >= RUN_MAX) ? RUN_MAX : r + 1;
    endfunction

    // one band row; left neighbor is already this row's value, up is last row's
    function void score_row(logic [7:0] b);
      int     bw, ir, dr;
      longint ls, us, ds, upc, lfc, dgc, mx;
      logic [DIR_W-1:0] ld, ud;
      int     lr, ur;
      bit     eq;
      bw = (bw_reg > BAND) ? BAND : bw_reg;
      for (int c = 1; c < bw; c++) begin
        ls = 0; us = 0; ds = band_sc[c]; ld = DIR_STOP; ud = DIR_STOP;
        lr = 0; ur = 0; ir = 0; dr = 0;
        eq = (b == win[c-1]);
        if (c > 1) begin
          ls = band_sc[c-1]; ld = dir[c-1]; lr = run[c-1];
        end
        if (c + 1 < bw) begin
          us = band_sc[c+1]; ud = dir[c+1]; ur = run[c+1];
        end
        dgc = ds + (eq ? longint'(match_s) : longint'(mism_s));
        if (ud == DIR_I) begin
          ir = ur;
          upc = (us == 0) ? 0 : us + gap_ext(ir);
        end else begin
          upc = us + open_rd;
        end
        if (ld == DIR_D) begin
          dr = lr;
          lfc = (ls == 0) ? 0 : ls + gap_ext(dr);
        end else begin
          lfc = ls + open_rf;
        end
        mx = 0;
        if (lfc > mx) mx = lfc;
        if (dgc > mx) mx = dgc;
        if (upc > mx) mx = upc;
        // tie order: deletion run, insertion run, diagonal, new deletion, new insertion
        if (dr > 0 && mx == lfc) begin
          dir[c] = DIR_D; run[c] = bump(dr);
        end else if (ir > 0 && mx == upc) begin
          dir[c] = DIR_I; run[c] = bump(ir);
        end else if (mx == dgc) begin
          dir[c] = eq ? DIR_EQ : DIR_X; run[c] = 0;
        end else if (mx == lfc) begin
          dir[c] = DIR_D; run[c] = 1;
        end else if (mx == upc) begin
          dir[c] = DIR_I; run[c] = 1;
        end else begin
          dir[c] = DIR_STOP; run[c] = 0; mx = 0;
        end
        if (mx > SCORE_SAT) mx = SCORE_SAT;
        band_sc[c] = mx;
        if (mx > top_sc) begin
          top_sc = mx; top_row = rows; top_col = c - 1;
        end
      end
      for (int i = 0; i < BAND - 1; i++) win[i] = win[i+1];
      win[BAND-1] = 8'd0;
      if (fill > 0) fill--;
      if (rows < 65535) rows++;
    endfunction

    function void note_beat(logic [1:0] kind, logic [7:0] b);
      align_res_t r;
      beats++;
      case (kind)
        KIND_REF: begin
          if (fill < BAND) begin
            win[fill] = b; fill++;
          end
        end
        KIND_READ: score_row(b);
        KIND_FINISH: begin
          r.score = top_sc[24:0];
          if (rows == 0) begin
            r.row = 16'd2; r.col = 6'd2; r.clip = 16'd0;
          end else begin
            r.row = top_row[15:0]; r.col = top_col[5:0];
            r.clip = (rows > top_row) ? 16'(rows - top_row - 1) : 16'd0;
          end
          owed.push_back(r);
          clear();
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [63:0] d);
      align_res_t e;
      seen++;
      if (owed.size() == 0) begin
        $error("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (d[24:0] !== e.score) begin
        $error("best_score exp %0d got %0d", e.score, $signed(d[24:0])); errors++;
      end
      if (d[40:25] !== e.row) begin
        $error("best_read_row exp %0d got %0d", e.row, d[40:25]); errors++;
      end
      if (d[46:41] !== e.col) begin
        $error("best_band_col exp %0d got %0d", e.col, d[46:41]); errors++;
      end
      if (d[62:47] !== e.clip) begin
        $error("end_clip exp %0d got %0d", e.clip, d[62:47]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] base
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // score, row, col, clip from bit 0 up
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [14:0] cfg_data_i = '0;

  align_board sb = new();
  bit         calm = 1'b0;      // no idling on either side while set
  bit         hold_rx = 1'b0;   // requests one long receiver hold-off (HOLD_CYC)
  longint     cyc = 0;
  int         n_cfg = 0;
  logic [7:0] refseq[$];

  always #6 clk_i = ~clk_i;

  banded_local_align_score #(.BAND(BAND), .RUN_MAX(RUN_MAX)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_addr_i, .cfg_data_i
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_rx = 1'b0;
      end
      m_axis_tready = calm || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // drive one beat; valid stays high into the next call when no gap is taken
  task automatic send(logic [1:0] kind, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(kind, b);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic wr_cfg(logic [2:0] idx, int v);
    cfg_we_i   = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = v[14:0];
    sb.set_reg(idx, v[14:0]);
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic int pick_pen();
    case ($urandom_range(0, 5))
      0: return -10000;
      1: return 0;
      default: return -int'($urandom_range(0, 1200));
    endcase
  endfunction

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'd0;
      default: return 8'("ACGT" >> (8 * $urandom_range(0, 3)));
    endcase
  endfunction

  task automatic rand_cfg();
    int v;
    v = $urandom_range(0, 7);
    wr_cfg(CFG_MATCH, (v == 0) ? 0 : (v == 1) ? 10000 : $urandom_range(50, 600));
    v = $urandom_range(0, 7);
    wr_cfg(CFG_MISMATCH, (v == 0) ? -10000 : (v == 1) ? 10000 :
                         -int'($urandom_range(0, 800)));
    wr_cfg(CFG_OPEN_RD, pick_pen());
    wr_cfg(CFG_OPEN_RF, pick_pen());
    wr_cfg(CFG_EXT_BASE, pick_pen());
    v = $urandom_range(0, 7);
    wr_cfg(CFG_EXT_DEC, (v == 0) ? 0 : (v == 1) ? 10000 : $urandom_range(0, 300));
    wr_cfg(CFG_EXT_CAP, pick_pen());
    v = $urandom_range(0, 19);
    wr_cfg(CFG_BAND_W, (v == 0) ? 0 : (v == 1) ? 1 : (v == 2) ? 64 : (v == 3) ? 127 :
                       $urandom_range(2, 12));
  endtask

  // one alignment: reference bases, reads mostly copied from them, then finish
  task automatic alignment();
    int nref, nread;
    nref  = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 14);
    nread = $urandom_range(0, 16);
    refseq.delete();
    for (int i = 0; i < nref; i++) begin
      refseq.push_back(pick_base());
      send(KIND_REF, refseq[i]);
    end
    for (int i = 0; i < nread; i++) begin
      if ($urandom_range(0, 19) == 0) send(KIND_NONE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) send(KIND_REF, pick_base());
      send(KIND_READ, (i < refseq.size() && $urandom_range(0, 9) < 7) ? refseq[i]
                                                                       : pick_base());
    end
    send(KIND_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, empty read, extreme bases, unused kind
    send(KIND_FINISH, 8'h00);
    send(KIND_REF, 8'h00);
    send(KIND_REF, 8'hFF);
    send(KIND_REF, "A");
    send(KIND_READ, 8'hFF);
    send(KIND_READ, "A");
    send(KIND_NONE, 8'hFF);
    send(KIND_READ, 8'h00);
    send(KIND_FINISH, 8'hFF);
    drain();
    // band width below 2: no cells at all
    wr_cfg(CFG_BAND_W, 1);
    send(KIND_READ, "C");
    send(KIND_FINISH, 8'h00);
    drain();
    // oversized band width, register extremes
    wr_cfg(CFG_BAND_W, 127);
    wr_cfg(CFG_MATCH, 10000);
    wr_cfg(CFG_MISMATCH, 10000);
    wr_cfg(CFG_OPEN_RD, 0);
    wr_cfg(CFG_OPEN_RF, -10000);
    wr_cfg(CFG_EXT_BASE, 0);
    wr_cfg(CFG_EXT_DEC, 10000);
    wr_cfg(CFG_EXT_CAP, 0);
    for (int i = 0; i < 4; i++) send(KIND_REF, "G");
    for (int i = 0; i < 4; i++) send(KIND_READ, (i[0]) ? "G" : "T");
    send(KIND_FINISH, 8'h00);
    drain();
    wr_cfg(CFG_MISMATCH, -10000);
    wr_cfg(CFG_OPEN_RD, -10000);
    wr_cfg(CFG_OPEN_RF, 0);
    wr_cfg(CFG_EXT_BASE, -10000);
    wr_cfg(CFG_EXT_DEC, 0);
    wr_cfg(CFG_EXT_CAP, -10000);
    wr_cfg(CFG_MATCH, 0);
    send(KIND_READ, "T");
    send(KIND_FINISH, 8'h00);
    drain();

    // score saturation: zero bases match the empty window every row
    calm = 1'b1;
    wr_cfg(CFG_MATCH, 10000);
    wr_cfg(CFG_BAND_W, 2);
    for (int i = 0; i < 1700; i++) send(KIND_READ, 8'h00);
    send(KIND_FINISH, 8'h00);
    drain();
    calm = 1'b0;

    // receiver holds off while finishes pile up behind the result register
    wr_cfg(CFG_BAND_W, 4);
    hold_rx = 1'b1;
    for (int i = 0; i < 4; i++) alignment();
    drain();

    // random phases; one of them runs without idling
    for (int ph = 0; sb.beats < 2000; ph++) begin
      rand_cfg();
      calm = (ph == 3);
      for (int a = 0; a < 8; a++) alignment();
      drain();
    end
    calm = 1'b0;

    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d input beats, %0d results, %0d register writes;",
             sb.beats, sb.seen, n_cfg);
    $display("incl. score saturation, full window, long output stall.");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: banded_local_align_score.f
+incdir+rtl/core
rtl/core/blas_pkg.sv
rtl/core/blas_ram.sv
rtl/core/blas_ctrl.sv
rtl/core/blas_datapath.sv
rtl/core/banded_local_align_score.sv
rtl/core/blas_checker.sv
tb/banded_local_align_score_tb.sv
